@@ rtl/core/hkrd_pkg.sv @@
// hkrd_pkg: shared constants, types and helpers for the keyboard report diff block
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package hkrd_pkg;

  localparam int unsigned KEY_SLOTS_DEF = 6;   // slots kept between reports
  localparam int unsigned INPUT_SLOTS   = 6;   // key slots carried by a boot report
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned MOD_W         = 8;

  localparam logic [LEN_W-1:0] MIN_REPORT_LEN = 7'd8;

  localparam logic [MOD_W-1:0] SHIFT_MASK = 8'h22;
  localparam logic [MOD_W-1:0] CTRL_MASK  = 8'h11;
  localparam logic [MOD_W-1:0] ALT_MASK   = 8'h44;
  localparam logic [MOD_W-1:0] META_MASK  = 8'h88;

  // held-modifier flags that ride along with every event of a report
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic meta;
  } mods_t;

  function automatic mods_t decode_mods(input logic [MOD_W-1:0] bits);
    mods_t m;
    m.shift = |(bits & SHIFT_MASK);
    m.ctrl  = |(bits & CTRL_MASK);
    m.alt   = |(bits & ALT_MASK);
    m.meta  = |(bits & META_MASK);
    return m;
  endfunction

endpackage

@@ rtl/core/hkrd_lane.sv @@
// hkrd_lane: one compare lane, flags a nonzero key code missing from a slot set
// depends on hkrd_pkg
`timescale 1ns / 1ps

module hkrd_lane #(
  parameter int unsigned KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF
) (
  input  logic [hkrd_pkg::CODE_W-1:0]                code,
  input  logic [KEY_SLOTS-1:0][hkrd_pkg::CODE_W-1:0] other_set,
  output logic                                       changed
);
  import hkrd_pkg::*;

  logic [KEY_SLOTS-1:0] hit;

  always_comb begin
    for (int j = 0; j < KEY_SLOTS; j++) begin
      hit[j] = (other_set[j] == code);
    end
  end

  // empty slot never produces an event
  assign changed = (code != '0) && !(|hit);

endmodule

@@ rtl/core/hkrd_merge.sv @@
// hkrd_merge: holds a report's lane results, emits one beat a cycle if not stalled
// depends on hkrd_pkg
`timescale 1ns / 1ps

module hkrd_merge #(
  parameter int unsigned KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         load,
  input  logic [2*KEY_SLOTS-1:0]                       load_mask,
  input  logic [2*KEY_SLOTS-1:0][hkrd_pkg::CODE_W-1:0] load_codes,
  input  hkrd_pkg::mods_t                              load_mods,
  output logic                                         busy,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [hkrd_pkg::CODE_W-1:0]                  out_usage_code,
  output logic                                         out_is_press,
  output logic                                         out_shift_held,
  output logic                                         out_ctrl_held,
  output logic                                         out_alt_held,
  output logic                                         out_meta_held,
  output logic                                         out_last_of_run
);
  import hkrd_pkg::*;

  localparam int unsigned EV = 2 * KEY_SLOTS;

  logic [EV-1:0]             mask_r, mask_nxt;
  logic [EV-1:0][CODE_W-1:0] codes_r;
  mods_t                     mods_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]         code_r;
  logic                      press_r;
  logic                      last_r;

  logic                      out_free;
  logic                      pop;
  logic [EV-1:0]             low;
  logic [EV-1:0]             mask_left;
  logic [CODE_W-1:0]         sel_code;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = out_free && (|mask_r);
  // lowest pending event: releases sit in the low half, presses in the high half
  assign low       = mask_r & (~mask_r + EV'(1));
  assign mask_left = pop ? (mask_r & ~low) : mask_r;
  assign busy      = |mask_left;
  assign mask_nxt  = load ? load_mask : mask_left;

  always_comb begin
    sel_code = '0;
    for (int i = 0; i < EV; i++) begin
      sel_code = sel_code | (low[i] ? codes_r[i] : '0);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codes_r <= load_codes;
      mods_r  <= load_mods;
    end
    if (pop) begin
      code_r  <= sel_code;
      press_r <= |low[EV-1:KEY_SLOTS];
      last_r  <= !(|mask_left);
      out_shift_held <= mods_r.shift;
      out_ctrl_held  <= mods_r.ctrl;
      out_alt_held   <= mods_r.alt;
      out_meta_held  <= mods_r.meta;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_usage_code  = code_r;
  assign out_is_press    = press_r;
  assign out_last_of_run = last_r;

endmodule

@@ rtl/core/hid_keyboard_report_diff.sv @@
// hid_keyboard_report_diff: top level, boot keyboard report in, key press/release beats out
// depends on hkrd_pkg, hkrd_lane, hkrd_merge
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// in_*      in   in_valid / in_stall    len_bytes, modifier_bits, key_slot_0..5
// out_*     out  out_valid / out_stall  usage_code, is_press, four held flags, last_of_run
//
// a report is compared against the stored slots in the cycle it is accepted
// one event beat leaves per cycle while out_stall is low; a report yields at most
// 2 * KEY_SLOTS event beats, drained from the event mask by the single output register
// short reports (length below 8) and reports with no change yield no event beats
// synchronous active-low reset clears the stored slots and all valid state
// out_stall holds the output beat; the next report waits only while events are pending

module hid_keyboard_report_diff #(
  parameter int unsigned KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF  // 1 .. 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hkrd_pkg::LEN_W-1:0]           in_len_bytes,
  input  logic [hkrd_pkg::MOD_W-1:0]           in_modifier_bits,
  input  logic [hkrd_pkg::CODE_W-1:0]          in_key_slot_0,
  input  logic [hkrd_pkg::CODE_W-1:0]          in_key_slot_1,
  input  logic [hkrd_pkg::CODE_W-1:0]          in_key_slot_2,
  input  logic [hkrd_pkg::CODE_W-1:0]          in_key_slot_3,
  input  logic [hkrd_pkg::CODE_W-1:0]          in_key_slot_4,
  input  logic [hkrd_pkg::CODE_W-1:0]          in_key_slot_5,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hkrd_pkg::CODE_W-1:0]          out_usage_code,
  output logic                                 out_is_press,
  output logic                                 out_shift_held,
  output logic                                 out_ctrl_held,
  output logic                                 out_alt_held,
  output logic                                 out_meta_held,
  output logic                                 out_last_of_run
);
  import hkrd_pkg::*;

  localparam int unsigned EV = 2 * KEY_SLOTS;

  // slots of the last full-length report, the only state kept between reports
  logic [KEY_SLOTS-1:0][CODE_W-1:0]   prev_r, prev_nxt;

  logic [INPUT_SLOTS-1:0][CODE_W-1:0] in_slots;
  logic [KEY_SLOTS-1:0][CODE_W-1:0]   now_slots;
  logic [EV-1:0]                      ev_mask;
  logic [EV-1:0][CODE_W-1:0]          ev_codes;
  logic                               in_accept;
  logic                               long_report;
  logic                               load;
  logic                               busy;

  assign in_slots = {in_key_slot_5, in_key_slot_4, in_key_slot_3,
                     in_key_slot_2, in_key_slot_1, in_key_slot_0};

  // slots past the six in a boot report read as empty; extra input slots drop
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_now
    if (i < INPUT_SLOTS) begin : g_in
      assign now_slots[i] = in_slots[i];
    end else begin : g_pad
      assign now_slots[i] = '0;
    end
  end

  // release lanes: each stored key looked up in the new slots
  // press lanes: each new key looked up in the stored slots
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    hkrd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_rel (
      .code      (prev_r[i]),
      .other_set (now_slots),
      .changed   (ev_mask[i])
    );
    hkrd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_prs (
      .code      (now_slots[i]),
      .other_set (prev_r),
      .changed   (ev_mask[KEY_SLOTS + i])
    );
    assign ev_codes[i]             = prev_r[i];
    assign ev_codes[KEY_SLOTS + i] = now_slots[i];
  end

  // a new report is taken once the pending event mask drains this cycle
  assign in_stall    = busy;
  assign in_accept   = in_valid && !in_stall;
  assign long_report = (in_len_bytes >= MIN_REPORT_LEN);
  assign load        = in_accept && long_report;
  assign prev_nxt    = load ? now_slots : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  hkrd_merge #(.KEY_SLOTS(KEY_SLOTS)) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .load_mask       (ev_mask),
    .load_codes      (ev_codes),
    .load_mods       (decode_mods(in_modifier_bits)),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_usage_code  (out_usage_code),
    .out_is_press    (out_is_press),
    .out_shift_held  (out_shift_held),
    .out_ctrl_held   (out_ctrl_held),
    .out_alt_held    (out_alt_held),
    .out_meta_held   (out_meta_held),
    .out_last_of_run (out_last_of_run)
  );

  // short report leaves the stored slots alone
  a_short_keeps_slots : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !long_report) |=> $stable(prev_r))
    else $error("short report changed stored slots");

  // a run does not end early: after a taken beat that is not last, another follows
  a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_run) |=> out_valid)
    else $error("event run ended without last_of_run");

  // presses come after all releases of the same report
  a_press_after_release : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_is_press && !out_last_of_run) |=> out_is_press)
    else $error("release beat followed a press beat in one run");

endmodule
